/* hw/rtl/wmbus_crc_pkg.sv */
package wmbus_crc_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h3D65;
    localparam logic [15:0] CRC_XOR_OUT = 16'hFFFF;

    localparam logic [7:0] L_MIN        = 8'd10;
    localparam logic [7:0] L_B_SPLIT    = 8'd128;
    localparam logic [7:0] L_B_SHORT_MAX = 8'd127;
    localparam logic [8:0] A_FIRST_LEN  = 9'd10;
    localparam logic [8:0] A_BLOCK_LEN  = 9'd16;
    localparam logic [8:0] B_FIRST_LEN  = 9'd126;
    localparam logic [8:0] B_ONE_BLOCK_MAX = 9'd128;

    localparam logic [1:0] PHASE_DATA = 2'd0;
    localparam logic [1:0] PHASE_CRC_HI = 2'd1;
    localparam logic [1:0] PHASE_CRC_LO = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [1:0] STATUS_TRUNC   = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       format_b;
    } t_in;

    typedef struct packed {
        logic       is_status;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_out;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* hw/rtl/wmbus_block_crc_deframer.sv */
// Channel   Direction  Payload  Handshake
// input     in         t_in     i_valid / o_ready
// result    out        t_out    o_valid / i_ready
//
// Each byte is decoded, checked and its CRC updated in the cycle it is transferred in.
// Results go into a four-entry output queue; the first result is visible in the cycle after the transfer.
// A byte transfer can happen every cycle while the queue holds two or fewer results.
// A frame start during an open frame produces two results: a truncation status, then the new start byte's result.
// Reset clears the frame state and empties the queue.
module wmbus_block_crc_deframer
    import wmbus_crc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic        r_in_frame, n_in_frame;
    logic        r_fmt_is_b, n_fmt_is_b;
    logic [8:0]  r_frame_total, n_frame_total;
    logic [8:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_block_left, n_block_left;
    logic [1:0]  r_crc_phase, n_crc_phase;
    logic [15:0] r_running_crc, n_running_crc;
    logic [7:0]  r_crc_high_seen, n_crc_high_seen;
    logic        r_error_seen, n_error_seen;

    t_out              r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic       in_xfer;
    logic       out_xfer;
    logic       trunc;
    logic       main_valid;
    t_out       main_res;
    t_out       slot0;
    t_out       slot1;
    logic [1:0] push_n;

    logic [7:0]  b;
    logic        bad_len;
    logic [4:0]  a_blocks;
    logic [8:0]  idx_inc;
    logic [8:0]  rem;
    logic [7:0]  left_dec;
    logic [15:0] crc_got;
    logic        crc_bad;
    logic [8:0]  b_total;
    logic [8:0]  first_len;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;
    assign o_ready  = r_count <= QCNT_W'(QDEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_data   = r_queue[r_rd_ptr];

    assign b        = i_data.rx_byte;
    assign bad_len  = (b < L_MIN) || (i_data.format_b && (b == L_MIN || b == L_B_SPLIT));
    assign a_blocks = 5'd1 + 5'((9'(b) + 9'd6) >> 4);
    assign b_total  = 9'(b) + 9'd1;
    assign idx_inc  = r_byte_index + 9'd1;
    assign rem      = r_frame_total - idx_inc - 9'd2;
    assign left_dec = (r_block_left != '0) ? r_block_left - 8'd1 : r_block_left;
    assign crc_got  = {r_crc_high_seen, b};
    assign crc_bad  = crc_got != (r_running_crc ^ CRC_XOR_OUT);

    always_comb begin
        n_in_frame      = r_in_frame;
        n_fmt_is_b      = r_fmt_is_b;
        n_frame_total   = r_frame_total;
        n_byte_index    = r_byte_index;
        n_block_left    = r_block_left;
        n_crc_phase     = r_crc_phase;
        n_running_crc   = r_running_crc;
        n_crc_high_seen = r_crc_high_seen;
        n_error_seen    = r_error_seen;
        trunc           = 1'b0;
        main_valid      = 1'b0;
        main_res        = '0;
        first_len       = A_FIRST_LEN;

        if (in_xfer) begin
            if (i_data.frame_start) begin
                trunc      = r_in_frame;
                n_in_frame = 1'b0;
                main_valid = 1'b1;
                if (bad_len) begin
                    main_res = '{is_status: 1'b1, out_byte: 8'd0,
                                 status: STATUS_BAD_LEN, last: 1'b1};
                end else begin
                    n_fmt_is_b = i_data.format_b;
                    if (i_data.format_b) begin
                        n_frame_total = b_total;
                        first_len = (b_total <= B_ONE_BLOCK_MAX) ? b_total - 9'd2
                                                                 : B_FIRST_LEN;
                        main_res.out_byte = (b <= L_B_SHORT_MAX) ? b - 8'd2 : b - 8'd4;
                    end else begin
                        n_frame_total = b_total + {3'd0, a_blocks, 1'b0};
                        first_len = A_FIRST_LEN;
                        main_res.out_byte = b;
                    end
                    n_in_frame    = 1'b1;
                    n_error_seen  = 1'b0;
                    n_byte_index  = 9'd1;
                    n_running_crc = crc_byte(16'h0000, b);
                    n_block_left  = 8'(first_len - 9'd1);
                    n_crc_phase   = (first_len == 9'd1) ? PHASE_CRC_HI : PHASE_DATA;
                end
            end else if (r_in_frame) begin
                n_byte_index = idx_inc;
                case (r_crc_phase)
                    PHASE_DATA: begin
                        n_running_crc = crc_byte(r_running_crc, b);
                        main_valid = 1'b1;
                        main_res.out_byte = b;
                        n_block_left = left_dec;
                        if (left_dec == '0) begin
                            n_crc_phase = PHASE_CRC_HI;
                        end
                    end
                    PHASE_CRC_HI: begin
                        n_crc_high_seen = b;
                        n_crc_phase = PHASE_CRC_LO;
                    end
                    default: begin
                        n_error_seen = r_error_seen || crc_bad;
                        if (idx_inc >= r_frame_total) begin
                            main_valid = 1'b1;
                            main_res = '{is_status: 1'b1, out_byte: 8'd0,
                                         status: n_error_seen ? STATUS_CRC_ERR : STATUS_OK,
                                         last: 1'b1};
                            n_in_frame   = 1'b0;
                            n_crc_phase  = PHASE_DATA;
                            n_block_left = '0;
                        end else begin
                            if (!r_fmt_is_b && rem > A_BLOCK_LEN) begin
                                n_block_left = 8'(A_BLOCK_LEN);
                            end else begin
                                n_block_left = rem[7:0];
                            end
                            n_running_crc = '0;
                            n_crc_phase = (n_block_left == '0) ? PHASE_CRC_HI : PHASE_DATA;
                        end
                    end
                endcase
            end
        end

        slot1  = main_res;
        slot0  = trunc ? t_out'{is_status: 1'b1, out_byte: 8'd0,
                                status: STATUS_TRUNC, last: 1'b1}
                       : main_res;
        push_n = {1'b0, trunc} + {1'b0, main_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_fmt_is_b      <= 1'b0;
            r_frame_total   <= '0;
            r_byte_index    <= '0;
            r_block_left    <= '0;
            r_crc_phase     <= PHASE_DATA;
            r_running_crc   <= '0;
            r_crc_high_seen <= '0;
            r_error_seen    <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            r_in_frame      <= n_in_frame;
            r_fmt_is_b      <= n_fmt_is_b;
            r_frame_total   <= n_frame_total;
            r_byte_index    <= n_byte_index;
            r_block_left    <= n_block_left;
            r_crc_phase     <= n_crc_phase;
            r_running_crc   <= n_running_crc;
            r_crc_high_seen <= n_crc_high_seen;
            r_error_seen    <= n_error_seen;
            r_wr_ptr        <= r_wr_ptr + QPTR_W'(push_n);
            r_rd_ptr        <= r_rd_ptr + QPTR_W'(out_xfer);
            r_count         <= r_count + QCNT_W'(push_n) - QCNT_W'(out_xfer);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= slot0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= slot1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crc_phase != 2'd3)
        else $error("invalid CRC phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_byte_index < r_frame_total))
        else $error("byte index ran past the frame length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_data.frame_start && r_in_frame) |-> (push_n == 2'd2))
        else $error("early frame start must yield truncation and a second result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_data.frame_start && !r_in_frame) |=> (r_count <= $past(r_count)))
        else $error("byte outside a frame produced a result");

endmodule

/* bench/wmbus_deframer_checker.sv */
module wmbus_deframer_checker
    import wmbus_crc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    logic        frame_open;
    logic        fmt_b;
    logic [8:0]  frame_len;
    logic [8:0]  bytes_taken;
    logic [7:0]  data_left;
    logic [1:0]  crc_stage;
    logic [15:0] crc_acc;
    logic [7:0]  crc_hi_byte;
    logic        crc_fail;
    t_out        deframed_q[$];
    t_out        oldest;
    int          fails = 0;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic queue_result(input logic st, input logic [7:0] b, input logic [1:0] s);
        t_out r;
        r.is_status = st;
        r.out_byte  = b;
        r.status    = s;
        r.last      = st;
        deframed_q.push_back(r);
    endtask

    task automatic predict_deframe(input t_in item);
        int          lv;
        int          total;
        int          first;
        int          adj;
        int          blocks;
        int          rem;
        logic [15:0] got;
        lv = int'(item.rx_byte);
        if (item.frame_start) begin
            if (frame_open) begin
                queue_result(1'b1, 8'h00, STATUS_TRUNC);
                frame_open = 1'b0;
            end
            if (item.rx_byte < L_MIN
                || (item.format_b && (item.rx_byte == L_MIN || item.rx_byte == L_B_SPLIT))) begin
                queue_result(1'b1, 8'h00, STATUS_BAD_LEN);
            end else begin
                if (item.format_b) begin
                    total = lv + 1;
                    first = (total <= 128) ? total - 2 : 126;
                    adj   = (lv <= 127) ? lv - 2 : lv - 4;
                end else begin
                    blocks = 1 + (lv - 9 + 15) / 16;
                    total  = lv + 1 + 2 * blocks;
                    first  = 10;
                    adj    = lv;
                end
                fmt_b       = item.format_b;
                frame_len   = 9'(total);
                frame_open  = 1'b1;
                crc_fail    = 1'b0;
                bytes_taken = 9'd1;
                crc_acc     = crc16_step(16'h0000, item.rx_byte);
                data_left   = 8'(first - 1);
                crc_stage   = (data_left == 8'd0) ? PHASE_CRC_HI : PHASE_DATA;
                queue_result(1'b0, 8'(adj), STATUS_OK);
            end
        end else if (frame_open) begin
            case (crc_stage)
                PHASE_DATA: begin
                    crc_acc     = crc16_step(crc_acc, item.rx_byte);
                    bytes_taken = bytes_taken + 9'd1;
                    queue_result(1'b0, item.rx_byte, STATUS_OK);
                    if (data_left > 8'd0) begin
                        data_left = data_left - 8'd1;
                    end
                    if (data_left == 8'd0) begin
                        crc_stage = PHASE_CRC_HI;
                    end
                end
                PHASE_CRC_HI: begin
                    crc_hi_byte = item.rx_byte;
                    bytes_taken = bytes_taken + 9'd1;
                    crc_stage   = PHASE_CRC_LO;
                end
                default: begin
                    got = {crc_hi_byte, item.rx_byte};
                    if (got != ~crc_acc) begin
                        crc_fail = 1'b1;
                    end
                    bytes_taken = bytes_taken + 9'd1;
                    if (bytes_taken >= frame_len) begin
                        queue_result(1'b1, 8'h00, crc_fail ? STATUS_CRC_ERR : STATUS_OK);
                        frame_open = 1'b0;
                        crc_stage  = PHASE_DATA;
                        data_left  = 8'd0;
                    end else begin
                        rem = int'(frame_len) - int'(bytes_taken) - 2;
                        if (!fmt_b && rem > 16) begin
                            rem = 16;
                        end
                        data_left = 8'(rem);
                        crc_acc   = 16'h0000;
                        crc_stage = (rem == 0) ? PHASE_CRC_HI : PHASE_DATA;
                    end
                end
            endcase
        end
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_open  = 1'b0;
            fmt_b       = 1'b0;
            frame_len   = '0;
            bytes_taken = '0;
            data_left   = '0;
            crc_stage   = PHASE_DATA;
            crc_acc     = '0;
            crc_hi_byte = '0;
            crc_fail    = 1'b0;
            deframed_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (deframed_q.size() == 0) begin
                    $error("result transfer with nothing expected: %0h", i_out_data);
                    fails++;
                end else begin
                    oldest = deframed_q.pop_front();
                    check_field("is_status", int'(oldest.is_status),
                                int'(i_out_data.is_status));
                    check_field("out_byte", int'(oldest.out_byte), int'(i_out_data.out_byte));
                    check_field("status", int'(oldest.status), int'(i_out_data.status));
                    check_field("last", int'(oldest.last), int'(i_out_data.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_deframe(i_in_data);
            end
        end
        o_fail_count <= fails;
        o_pending    <= deframed_q.size();
    end

endmodule

/* bench/wmbus_block_crc_deframer_tb.sv */
module wmbus_block_crc_deframer_tb;
    import wmbus_crc_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    int   fail_count;
    int   pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_left     = 0;
    int items_sent     = 0;
    int border_lens[]  = '{0, 9, 10, 11, 19, 20, 25, 26, 27, 126, 127, 128, 129, 130, 254, 255};

    wmbus_block_crc_deframer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    wmbus_deframer_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("wmbus_block_crc_deframer: mismatch");
        $finish;
    end

    // A pending hold-off keeps the receiver stalled while the sender keeps offering bytes.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_in make_item(input logic [7:0] b, input logic st, input logic fb);
        t_in item;
        item.rx_byte     = b;
        item.frame_start = st;
        item.format_b    = fb;
        return item;
    endfunction

    task automatic push_byte(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_frame(input int len, input logic fmt, input bit corrupt, input int cut);
        logic [7:0]  wire_q[$];
        int          sizes[$];
        int          left;
        int          pos;
        int          flip_at;
        int          n_send;
        logic [15:0] crc;
        logic [7:0]  b;
        if (len < 10 || (fmt && (len == 10 || len == 128))) begin
            push_byte(make_item(8'(len), 1'b1, fmt));
            items_sent++;
            return;
        end
        if (!fmt) begin
            sizes.push_back(10);
            left = len + 1 - 10;
            while (left > 0) begin
                sizes.push_back(left > 16 ? 16 : left);
                left -= 16;
            end
        end else if (len + 1 <= 128) begin
            sizes.push_back(len - 1);
        end else begin
            sizes.push_back(126);
            sizes.push_back(len - 129);
        end
        pos = 0;
        foreach (sizes[k]) begin
            crc = 16'h0000;
            for (int j = 0; j < sizes[k]; j++) begin
                b = (pos == 0) ? 8'(len) : 8'($urandom_range(255));
                crc = crc_byte(crc, b);
                wire_q.push_back(b);
                pos++;
            end
            wire_q.push_back(~crc[15:8]);
            wire_q.push_back(~crc[7:0]);
        end
        if (corrupt) begin
            flip_at = $urandom_range(wire_q.size() - 1, 1);
            wire_q[flip_at] = wire_q[flip_at] ^ 8'(1 << $urandom_range(7));
        end
        n_send = (cut > 0 && cut < wire_q.size()) ? cut : wire_q.size();
        for (int i = 0; i < n_send; i++) begin
            push_byte(make_item(wire_q[i], i == 0, (i == 0) ? fmt : 1'($urandom_range(1))));
            items_sent++;
        end
    endtask

    initial begin
        int nframes;
        int r;
        int len;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_byte(make_item(8'hFF, 1'b0, 1'b1));
        items_sent++;
        push_byte(make_item(8'h00, 1'b0, 1'b0));
        items_sent++;
        send_frame(0, 1'b0, 0, -1);
        send_frame(9, 1'b1, 0, -1);
        send_frame(10, 1'b1, 0, -1);
        send_frame(128, 1'b1, 0, -1);
        send_frame(10, 1'b0, 0, -1);
        send_frame(11, 1'b1, 1, -1);
        send_frame(20, 1'b0, 0, 5);
        send_frame(12, 1'b1, 0, 3);
        send_frame(5, 1'b0, 0, -1);
        stall_left = 60;
        send_frame(60, 1'b0, 0, -1);
        send_frame(129, 1'b1, 0, -1);

        nframes = 0;
        while (items_sent < 1750) begin
            case ((nframes / 3) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default: begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            r = $urandom_range(99);
            if (r < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    push_byte(make_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1))));
                    items_sent++;
                end
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    len = $urandom_range(10, 48);
                end else if (r < 85) begin
                    len = $urandom_range(255);
                end else begin
                    len = border_lens[$urandom_range(border_lens.size() - 1)];
                end
                send_frame(len, 1'($urandom_range(1)), $urandom_range(99) < 15,
                           ($urandom_range(99) < 10) ? $urandom_range(1, 20) : -1);
                nframes++;
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("wmbus_block_crc_deframer: match");
        end else begin
            $display("wmbus_block_crc_deframer: mismatch");
        end
        $finish;
    end

endmodule

/* wmbus_block_crc_deframer.f */
hw/rtl/wmbus_crc_pkg.sv
hw/rtl/wmbus_block_crc_deframer.sv
bench/wmbus_deframer_checker.sv
bench/wmbus_block_crc_deframer_tb.sv
